### hw/rtl/civ_pkg.sv
// Package with shared types, constants and helper functions of the civil id validator.
`timescale 1ns / 1ps

package civ_pkg;

    localparam int unsigned ID_LEN    = 10;
    localparam int unsigned COUNT_SAT = 11;
    localparam int unsigned REGION_N  = 29;
    localparam int unsigned SUM_LEN   = 9;

    localparam logic [9:0] REGION_BOUND [REGION_N] = '{
        10'd43,  10'd93,  10'd139, 10'd169, 10'd183, 10'd217, 10'd233, 10'd281,
        10'd301, 10'd319, 10'd341, 10'd377, 10'd395, 10'd435, 10'd501, 10'd527,
        10'd555, 10'd575, 10'd601, 10'd623, 10'd721, 10'd751, 10'd789, 10'd821,
        10'd843, 10'd871, 10'd903, 10'd925, 10'd999
    };

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_LENGTH   = 3'd1,
        ST_NONDIGIT = 3'd2,
        ST_CHECK    = 3'd3,
        ST_DATE     = 3'd4
    } civ_status_t;

    // Accumulated fields after the current character has been folded in
    typedef struct packed {
        logic [3:0] count;
        logic       nondigit;
        logic [3:0] sum;
        logic [6:0] year_code;
        logic [6:0] month_code;
        logic [6:0] day_code;
        logic [9:0] region_code;
        logic [3:0] digit;
    } civ_fields_t;

    typedef struct packed {
        civ_status_t status;
        logic [11:0] birth_year;
        logic [3:0]  birth_month;
        logic [4:0]  birth_day;
        logic [4:0]  region_index;
        logic [5:0]  born_before;
        logic        is_male;
    } civ_result_t;

    function automatic logic [3:0] weight_of(input logic [3:0] pos);
        logic [3:0] w;
        case (pos)
            4'd0:    w = 4'd2;
            4'd1:    w = 4'd4;
            4'd2:    w = 4'd8;
            4'd3:    w = 4'd5;
            4'd4:    w = 4'd10;
            4'd5:    w = 4'd9;
            4'd6:    w = 4'd7;
            4'd7:    w = 4'd3;
            4'd8:    w = 4'd6;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

    // x mod 11 for x <= 100, quotient by reciprocal 187/2048
    function automatic logic [3:0] mod11(input logic [7:0] x);
        logic [15:0] prod;
        logic [3:0]  q;
        logic [7:0]  r;
        prod = 16'(x) * 16'd187;
        q    = 4'(prod >> 11);
        r    = x - 8'(q) * 8'd11;
        return 4'(r);
    endfunction

    function automatic logic [9:0] mul10_add(input logic [9:0] v, input logic [3:0] d);
        return (v << 3) + (v << 1) + 10'(d);
    endfunction

    function automatic logic [4:0] region_of(input logic [9:0] rc);
        logic [4:0] idx;
        idx = 5'(REGION_N - 1);
        for (int i = REGION_N - 1; i >= 0; i--)
        begin
            if (rc <= REGION_BOUND[i])
            begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [9:0] region_lo(input logic [4:0] idx);
        logic [9:0] lo;
        if (idx == 5'd0)
        begin
            lo = 10'd0;
        end
        else
        begin
            lo = REGION_BOUND[idx - 5'd1] + 10'd1;
        end
        return lo;
    endfunction

endpackage

### hw/rtl/civ_accum.sv
// Per-character accumulator: count, non-digit flag, weighted sum mod 11 and digit fields.
`timescale 1ns / 1ps

module civ_accum (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic [7:0]          char_in,
    input  logic                last,
    output civ_pkg::civ_fields_t fields
);
    import civ_pkg::*;

    logic [3:0] count_reg,  count_next;
    logic       nondig_reg, nondig_next;
    logic [3:0] sum_reg,    sum_next;
    logic [6:0] year_reg,   year_next;
    logic [6:0] month_reg,  month_next;
    logic [6:0] day_reg,    day_next;
    logic [9:0] region_reg, region_next;

    logic       is_digit;
    logic [3:0] digit;
    logic [7:0] prod;

    always_comb
    begin
        is_digit    = (char_in >= 8'h30) && (char_in <= 8'h39);
        digit       = is_digit ? 4'(char_in - 8'h30) : 4'd0;
        prod        = 8'(digit) * 8'(weight_of(count_reg));
        nondig_next = nondig_reg | ~is_digit;
        sum_next    = sum_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        region_next = region_reg;
        if (count_reg < 4'(SUM_LEN))
        begin
            sum_next = mod11(8'(sum_reg) + prod);
        end
        if (count_reg < 4'd2)
        begin
            year_next = 7'(mul10_add(10'(year_reg), digit));
        end
        else if (count_reg < 4'd4)
        begin
            month_next = 7'(mul10_add(10'(month_reg), digit));
        end
        else if (count_reg < 4'd6)
        begin
            day_next = 7'(mul10_add(10'(day_reg), digit));
        end
        else if (count_reg < 4'(SUM_LEN))
        begin
            region_next = mul10_add(region_reg, digit);
        end
        count_next = (count_reg < 4'(COUNT_SAT)) ? count_reg + 4'd1 : count_reg;

        fields.count       = count_next;
        fields.nondigit    = nondig_next;
        fields.sum         = sum_next;
        fields.year_code   = year_next;
        fields.month_code  = month_next;
        fields.day_code    = day_next;
        fields.region_code = region_next;
        fields.digit       = digit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            nondig_reg <= 1'b0;
            sum_reg    <= '0;
            year_reg   <= '0;
            month_reg  <= '0;
            day_reg    <= '0;
            region_reg <= '0;
        end
        else if (fire)
        begin
            if (last)
            begin
                count_reg  <= '0;
                nondig_reg <= 1'b0;
                sum_reg    <= '0;
                year_reg   <= '0;
                month_reg  <= '0;
                day_reg    <= '0;
                region_reg <= '0;
            end
            else
            begin
                count_reg  <= count_next;
                nondig_reg <= nondig_next;
                sum_reg    <= sum_next;
                year_reg   <= year_next;
                month_reg  <= month_next;
                day_reg    <= day_next;
                region_reg <= region_next;
            end
        end
    end

endmodule

### hw/rtl/civ_check.sv
// Final checks: length, digits, check digit, date decode and region lookup.
`timescale 1ns / 1ps

module civ_check (
    input  civ_pkg::civ_fields_t fields,
    output civ_pkg::civ_result_t result
);
    import civ_pkg::*;

    logic [3:0]  expect_chk;
    logic [6:0]  month_dec;
    logic        cent_2000;
    logic [11:0] year_dec;
    logic        leap;
    logic        date_ok;
    logic [4:0]  ridx;
    logic [9:0]  rlo;
    logic [9:0]  roff;

    always_comb
    begin
        expect_chk = (fields.sum == 4'd10) ? 4'd0 : fields.sum;
        cent_2000  = 1'b0;
        if (fields.month_code > 7'd40)
        begin
            month_dec = fields.month_code - 7'd40;
            year_dec  = 12'd2000 + 12'(fields.year_code);
            cent_2000 = 1'b1;
        end
        else if (fields.month_code > 7'd20)
        begin
            month_dec = fields.month_code - 7'd20;
            year_dec  = 12'd1800 + 12'(fields.year_code);
        end
        else
        begin
            month_dec = fields.month_code;
            year_dec  = 12'd1900 + 12'(fields.year_code);
        end
        // century bases are multiples of 4; only 2000 is a multiple of 400
        leap = (fields.year_code[1:0] == 2'd0) && ((fields.year_code != 7'd0) || cent_2000);

        case (month_dec)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12:
                date_ok = (fields.day_code <= 7'd31);
            7'd4, 7'd6, 7'd9, 7'd11:
                date_ok = (fields.day_code <= 7'd30);
            7'd2:
                date_ok = (fields.day_code <= (leap ? 7'd29 : 7'd28));
            default:
                date_ok = 1'b0;
        endcase
        date_ok = date_ok && (fields.day_code != 7'd0);

        ridx = region_of(fields.region_code);
        rlo  = region_lo(ridx);
        roff = fields.region_code - rlo;

        result = '0;
        if (fields.count != 4'(ID_LEN))
        begin
            result.status = ST_LENGTH;
        end
        else if (fields.nondigit)
        begin
            result.status = ST_NONDIGIT;
        end
        else if (fields.digit != expect_chk)
        begin
            result.status = ST_CHECK;
        end
        else if (!date_ok)
        begin
            result.status     = ST_DATE;
            result.birth_year = year_dec;
        end
        else
        begin
            result.status       = ST_OK;
            result.birth_year   = year_dec;
            result.birth_month  = 4'(month_dec);
            result.birth_day    = 5'(fields.day_code);
            result.region_index = ridx;
            result.born_before  = 6'(roff >> 1);
            result.is_male      = ~fields.region_code[0];
        end
    end

endmodule

### hw/rtl/civil_id_number_validator_top.sv
// Top level of the civil id number validator: input register, accumulator, checks, result register.
`timescale 1ns / 1ps

// Takes one ASCII character per transaction, last marking the end of a number,
// and returns one result transaction per number. A character can be taken every
// clock cycle unless a held-back last character stalls the input. Characters pass
// through the input register; a number's result is loaded into the result register
// as its last character leaves, and result_valid stays high until it is taken. A
// finished result waiting in the result register only holds back the next last
// character, so ordinary characters keep flowing.
// Status codes: 0 ok, 1 wrong length, 2 non-digit, 3 bad check digit, 4 bad date;
// year is given for ok and bad date, all other fields only for ok. Accumulated
// state clears after every last character.
module civil_id_number_validator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_ready,
    input  logic [7:0]  char_in,
    input  logic        last,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [2:0]  status,
    output logic [11:0] birth_year,
    output logic [3:0]  birth_month,
    output logic [4:0]  birth_day,
    output logic [4:0]  region_index,
    output logic [5:0]  born_before,
    output logic        is_male
);
    import civ_pkg::*;

    logic        s1_valid_reg, s1_valid_next;
    logic [7:0]  s1_char_reg;
    logic        s1_last_reg;
    logic        s1_fire;
    logic        out_valid_reg, out_valid_next;
    civ_result_t out_reg;

    civ_fields_t fields;
    civ_result_t result;

    assign s1_fire    = s1_valid_reg && (!s1_last_reg || !out_valid_reg || result_ready);
    assign char_ready = !s1_valid_reg || s1_fire;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (char_valid && char_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_fire && s1_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_valid && char_ready)
        begin
            s1_char_reg <= char_in;
            s1_last_reg <= last;
        end
        if (s1_fire && s1_last_reg)
        begin
            out_reg <= result;
        end
    end

    civ_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (s1_fire),
        .char_in (s1_char_reg),
        .last    (s1_last_reg),
        .fields  (fields)
    );

    civ_check u_check (
        .fields (fields),
        .result (result)
    );

    assign result_valid = out_valid_reg;
    assign status       = out_reg.status;
    assign birth_year   = out_reg.birth_year;
    assign birth_month  = out_reg.birth_month;
    assign birth_day    = out_reg.birth_day;
    assign region_index = out_reg.region_index;
    assign born_before  = out_reg.born_before;
    assign is_male      = out_reg.is_male;

`ifndef ASSERT_OFF
    a_ok_has_date: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status == ST_OK) |-> (out_reg.birth_month != 4'd0
            && out_reg.birth_day != 5'd0 && out_reg.region_index <= 5'd28))
        else $error("ok result without a valid date or region");

    a_year_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != ST_OK && out_reg.status != ST_DATE)
            |-> (out_reg.birth_year == 12'd0))
        else $error("year reported for a number that failed before date decode");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |=> out_valid_reg)
        else $error("last character consumed without a result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_last_reg) |-> (!out_valid_reg || result_ready))
        else $error("pending result overwritten");
`endif

endmodule

### dv/tb_top.sv
// Self-checking testbench for the civil id number validator, with a built-in predictor.
`timescale 1ns / 1ps

module tb_top;
    import civ_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned SETTLE_CYCLES = 10;
    localparam int unsigned NO_BAD_POS = 10;
    localparam int unsigned CHECK_WEIGHT [9] = '{2, 4, 8, 5, 10, 9, 7, 3, 6};

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } char_txn_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        char_valid = 1'b0;
    logic        char_ready;
    logic [7:0]  char_in = 8'd0;
    logic        last = 1'b0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [2:0]  status;
    logic [11:0] birth_year;
    logic [3:0]  birth_month;
    logic [4:0]  birth_day;
    logic [4:0]  region_index;
    logic [5:0]  born_before;
    logic        is_male;

    // predictor state
    logic [3:0]  pos_count = 4'd0;
    logic        saw_nondigit = 1'b0;
    logic [3:0]  wsum = 4'd0;
    logic [6:0]  yy_code = 7'd0;
    logic [6:0]  mm_code = 7'd0;
    logic [6:0]  dd_code = 7'd0;
    logic [9:0]  rc_code = 10'd0;

    char_txn_t   pending_chars [$];
    civ_result_t results_due [$];
    char_txn_t   next_char;
    civ_result_t oldest_due;

    int unsigned items_queued = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned phase = 0;
    logic        hold_off = 1'b0;

    civil_id_number_validator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_ready   (char_ready),
        .char_in      (char_in),
        .last         (last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .birth_year   (birth_year),
        .birth_month  (birth_month),
        .birth_day    (birth_day),
        .region_index (region_index),
        .born_before  (born_before),
        .is_male      (is_male)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned month_days(input int unsigned yr, input int unsigned mon);
        logic leap;
        leap = (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
        case (mon)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    // Fold one accepted character into the state; on the final one, queue the result.
    task automatic absorb_char(input logic [7:0] ch, input logic fin);
        logic        is_digit;
        logic        found;
        logic [3:0]  dval;
        int unsigned yr;
        int unsigned mon;
        int unsigned lo;
        civ_result_t exp_res;
        is_digit = (ch >= 8'h30) && (ch <= 8'h39);
        dval = is_digit ? 4'(ch - 8'h30) : 4'd0;
        if (!is_digit)
            saw_nondigit = 1'b1;
        if (pos_count < 9)
            wsum = 4'((wsum + dval * CHECK_WEIGHT[pos_count]) % 11);
        if (pos_count < 2)
            yy_code = 7'(yy_code * 10 + dval);
        else if (pos_count < 4)
            mm_code = 7'(mm_code * 10 + dval);
        else if (pos_count < 6)
            dd_code = 7'(dd_code * 10 + dval);
        else if (pos_count < 9)
            rc_code = 10'(rc_code * 10 + dval);
        if (pos_count < COUNT_SAT)
            pos_count = pos_count + 4'd1;
        if (!fin)
            return;

        exp_res = '0;
        if (pos_count != ID_LEN)
            exp_res.status = ST_LENGTH;
        else if (saw_nondigit)
            exp_res.status = ST_NONDIGIT;
        else if (dval != ((wsum == 4'd10) ? 4'd0 : wsum))
            exp_res.status = ST_CHECK;
        else
        begin
            yr = yy_code;
            mon = mm_code;
            if (mon > 40)
            begin
                yr += 2000;
                mon -= 40;
            end
            else if (mon > 20)
            begin
                yr += 1800;
                mon -= 20;
            end
            else
            begin
                yr += 1900;
            end
            exp_res.birth_year = 12'(yr);
            if (dd_code == 0 || dd_code > month_days(yr, mon))
                exp_res.status = ST_DATE;
            else
            begin
                exp_res.status = ST_OK;
                exp_res.birth_month = 4'(mon);
                exp_res.birth_day = 5'(dd_code);
                exp_res.region_index = 5'(REGION_N - 1);
                lo = 0;
                found = 1'b0;
                for (int i = 0; i < REGION_N; i++)
                begin
                    if (!found && rc_code <= REGION_BOUND[i])
                    begin
                        exp_res.region_index = 5'(i);
                        found = 1'b1;
                    end
                    else if (!found)
                    begin
                        lo = REGION_BOUND[i] + 1;
                    end
                end
                exp_res.born_before = (rc_code >= lo) ? 6'((rc_code - lo) / 2) : 6'd0;
                exp_res.is_male = ~rc_code[0];
            end
        end
        results_due.push_back(exp_res);
        pos_count = 4'd0;
        saw_nondigit = 1'b0;
        wsum = 4'd0;
        yy_code = 7'd0;
        mm_code = 7'd0;
        dd_code = 7'd0;
        rc_code = 10'd0;
    endtask

    task automatic push_char(input logic [7:0] ch, input logic fin);
        pending_chars.push_back('{ch: ch, fin: fin});
        items_queued++;
    endtask

    // Ten characters from raw codes; check_off shifts the check digit, bad_pos swaps in bad_ch.
    task automatic send_digits(input int unsigned yc, input int unsigned mc,
                               input int unsigned dc, input int unsigned rc,
                               input int unsigned check_off, input int unsigned bad_pos,
                               input logic [7:0] bad_ch);
        int unsigned dig [10];
        int unsigned acc;
        dig[0] = yc / 10;
        dig[1] = yc % 10;
        dig[2] = mc / 10;
        dig[3] = mc % 10;
        dig[4] = dc / 10;
        dig[5] = dc % 10;
        dig[6] = rc / 100;
        dig[7] = (rc / 10) % 10;
        dig[8] = rc % 10;
        acc = 0;
        for (int i = 0; i < 9; i++)
            acc += dig[i] * CHECK_WEIGHT[i];
        acc = acc % 11;
        dig[9] = (((acc == 10) ? 0 : acc) + check_off) % 10;
        for (int i = 0; i < 10; i++)
            push_char((i == bad_pos) ? bad_ch : 8'(8'h30 + dig[i]), i == 9);
    endtask

    task automatic gen_number();
        int unsigned kind;
        int unsigned yr;
        int unsigned mon;
        int unsigned mc;
        int unsigned dc;
        int unsigned max_day;
        int unsigned len;
        logic [7:0]  bad_ch;
        kind = $urandom_range(99);
        yr = $urandom_range(2099, 1800);
        mon = $urandom_range(12, 1);
        max_day = month_days(yr, mon);
        mc = mon + ((yr >= 2000) ? 40 : ((yr < 1900) ? 20 : 0));
        dc = ($urandom_range(3) == 0) ? max_day : $urandom_range(max_day, 1);
        do
            bad_ch = 8'($urandom_range(255));
        while (bad_ch >= 8'h30 && bad_ch <= 8'h39);
        if (kind < 55)
            send_digits(yr % 100, mc, dc, $urandom_range(999), 0, NO_BAD_POS, 8'h00);
        else if (kind < 65)
            send_digits(yr % 100, mc, dc, $urandom_range(999), $urandom_range(9, 1),
                        NO_BAD_POS, 8'h00);
        else if (kind < 77)
        begin
            case ($urandom_range(3))
                0: dc = 0;
                1: dc = max_day + 1;
                2:
                begin
                    case ($urandom_range(3))
                        0: mc = 0;
                        1: mc = $urandom_range(20, 13);
                        2: mc = $urandom_range(40, 33);
                        default: mc = $urandom_range(99, 53);
                    endcase
                    dc = $urandom_range(31, 1);
                end
                default: dc = $urandom_range(99, 32);
            endcase
            send_digits(yr % 100, mc, dc, $urandom_range(999), 0, NO_BAD_POS, 8'h00);
        end
        else if (kind < 87)
            send_digits(yr % 100, mc, dc, $urandom_range(999), 0, $urandom_range(9), bad_ch);
        else if (kind < 95)
        begin
            len = $urandom_range(14, 1);
            if (len == 10)
                len = 11;
            for (int i = 0; i < len; i++)
                push_char(($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                                   : 8'(8'h30 + $urandom_range(9)),
                          i == len - 1);
        end
        else
        begin
            len = $urandom_range(5, 1);
            for (int i = 0; i < len; i++)
                push_char(8'($urandom_range(255)), $urandom_range(9) == 0);
        end
    endtask

    task automatic drain_all();
        while (pending_chars.size() != 0 || char_valid || results_due.size() != 0)
            @(negedge clk);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_in <= 8'd0;
            last <= 1'b0;
        end
        else if (!char_valid || char_ready)
        begin
            if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_char = pending_chars.pop_front();
                char_valid <= 1'b1;
                char_in <= next_char.ch;
                last <= next_char.fin;
            end
            else
            begin
                char_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_ready <= 1'b0;
        else
            result_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor: check results first, then fold in the accepted character
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (results_due.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result transaction: status %0d year %0d",
                                 status, birth_year);
                end
                else
                begin
                    oldest_due = results_due.pop_front();
                    if (oldest_due.status != status || oldest_due.birth_year != birth_year ||
                        oldest_due.birth_month != birth_month ||
                        oldest_due.birth_day != birth_day ||
                        oldest_due.region_index != region_index ||
                        oldest_due.born_before != born_before || oldest_due.is_male != is_male)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"result mismatch: expected st %0d y %0d m %0d d %0d ",
                                      "reg %0d bb %0d male %0d, got st %0d y %0d m %0d d %0d ",
                                      "reg %0d bb %0d male %0d"},
                                     oldest_due.status, oldest_due.birth_year,
                                     oldest_due.birth_month, oldest_due.birth_day,
                                     oldest_due.region_index, oldest_due.born_before,
                                     oldest_due.is_male, status, birth_year, birth_month,
                                     birth_day, region_index, born_before, is_male);
                    end
                end
            end
            if (char_valid && char_ready)
                absorb_char(char_in, last);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial
    begin
        wait (phase == 2);
        @(negedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_idle_pct = 17;
        recv_idle_pct = 88;
        push_char(8'h00, 1'b1);
        push_char(8'hFF, 1'b1);
        send_digits(0, 42, 29, 999, 0, NO_BAD_POS, 8'h00);
        send_digits(99, 12, 31, 0, 0, 4, 8'h2F);
        drain_all();
        while (items_queued < 300)
            gen_number();
        drain_all();

        send_idle_pct = 88;
        recv_idle_pct = 17;
        phase = 1;
        while (items_queued < 590)
            gen_number();
        drain_all();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        phase = 2;
        while (items_queued < 880)
            gen_number();
        drain_all();

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
